>>> rtl/ssc_pkg.sv
// ============================================================================
// ssc_pkg: shared types and constants for the shadow sphere cull block
// Opcodes, fixed-point field widths and the control word of the shared
// multiply-accumulate unit.
// ============================================================================
package ssc_pkg;

    // Item opcodes.
    localparam logic [1:0] OP_WPLANE = 2'd0;
    localparam logic [1:0] OP_WREACH = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Fixed field widths.
    localparam int DIR_W     = 18;
    localparam int RAD_W     = 31;
    localparam int LIM_SHIFT = 16;

    // Operands of squares are cut into chunks of this many bits.
    localparam int CHUNK_W   = 17;

    typedef logic signed [DIR_W-1:0] dir_t;

    // Control word from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic       issue;
        logic       load;
        logic       sub;
        logic [1:0] chunk;
    } mac_ctl_t;

endpackage

>>> rtl/ssc_mac.sv
// ============================================================================
// ssc_mac: shared multiply-accumulate unit
// One signed multiply per cycle into a product register; the next cycle adds
// or subtracts the product, shifted by its chunk position, into a wide
// accumulator.
// ============================================================================
module ssc_mac #(
    parameter int AW   = 33,
    parameter int ACCW = 73
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ssc_pkg::mac_ctl_t         ctl,
    input  logic signed [AW-1:0]      op_a,
    input  ssc_pkg::dir_t             op_b,
    input  logic signed [ACCW-1:0]    acc_init,
    output logic signed [ACCW-1:0]    acc
);
    import ssc_pkg::*;

    logic signed [AW+DIR_W-1:0] prod_reg;
    logic                       pv_reg;
    logic                       sub_reg;
    logic [1:0]                 sh_reg;
    logic signed [ACCW-1:0]     acc_reg;
    logic signed [ACCW-1:0]     psh;

    // Product stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= ctl.issue;
        end
        if (ctl.issue) begin
            prod_reg <= op_a * op_b;
            sub_reg  <= ctl.sub;
            sh_reg   <= ctl.chunk;
        end
    end

    // Place the product at its chunk weight.
    assign psh = ACCW'(prod_reg) <<< (CHUNK_W * int'(sh_reg));

    // Accumulate stage.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            acc_reg <= acc_init;
        end else if (pv_reg) begin
            acc_reg <= sub_reg ? acc_reg - psh : acc_reg + psh;
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/shadow_sphere_cull.sv
// ============================================================================
// shadow_sphere_cull: sphere test against reach spheres and a plane region
// Reach write, plane removal and clear go straight to the result word; a plane write
// first forms its offset on the shared unit. Test: each valid reach is checked for
// range and then for facing, ending at a hit; with a region present, each valid plane
// is checked, ending at a plane with the sphere outside. One item at a time on the
// shared unit.
// Synchronous active-low reset clears all valid bits and the region flag.
// ============================================================================
module shadow_sphere_cull #(
    parameter int MAX_PLANES  = 8,
    parameter int MAX_REACHES = 16,
    parameter int COORD_BITS  = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [3:0]                   s_slot,
    input  logic signed [COORD_BITS-1:0] s_pos_x,
    input  logic signed [COORD_BITS-1:0] s_pos_y,
    input  logic signed [COORD_BITS-1:0] s_pos_z,
    input  ssc_pkg::dir_t                s_dir_x,
    input  ssc_pkg::dir_t                s_dir_y,
    input  ssc_pkg::dir_t                s_dir_z,
    input  logic [ssc_pkg::RAD_W-1:0]    s_radius,
    input  logic                         s_enable,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_visible,
    output logic                         m_by_reach,
    output logic                         m_by_cascade
);
    import ssc_pkg::*;

    localparam int AW   = (COORD_BITS + 1 > 33) ? COORD_BITS + 1 : 33;
    localparam int NCH  = (AW + CHUNK_W - 1) / CHUNK_W;
    localparam int ACCW = AW + DIR_W + CHUNK_W * (NCH - 1) + 5;
    localparam int OFFW = COORD_BITS + 20;
    localparam int PIW  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PCW  = $clog2(MAX_PLANES + 1);
    localparam int RIW  = (MAX_REACHES > 1) ? $clog2(MAX_REACHES) : 1;
    localparam int RCW  = $clog2(MAX_REACHES + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WOFF   = 4'd1;
    localparam logic [3:0] S_WFL    = 4'd2;
    localparam logic [3:0] S_WST    = 4'd3;
    localparam logic [3:0] S_RSCAN  = 4'd4;
    localparam logic [3:0] S_SQ     = 4'd5;
    localparam logic [3:0] S_SQFL   = 4'd6;
    localparam logic [3:0] S_SQCHK  = 4'd7;
    localparam logic [3:0] S_DOT    = 4'd8;
    localparam logic [3:0] S_DOTFL  = 4'd9;
    localparam logic [3:0] S_DOTCHK = 4'd10;
    localparam logic [3:0] S_PSCAN  = 4'd11;
    localparam logic [3:0] S_PL     = 4'd12;
    localparam logic [3:0] S_PLFL   = 4'd13;
    localparam logic [3:0] S_PLCHK  = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    localparam logic [1:0] AX_FAR   = 2'd3;
    localparam logic [1:0] AX_LAST  = 2'd2;
    localparam logic [1:0] CH_LAST  = 2'(NCH - 1);

    logic [3:0]                   state_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg, cz_reg;
    logic [RAD_W-1:0]             r_reg;
    logic [PIW-1:0]               wslot_reg;
    logic [RCW-1:0]               ridx_reg;
    logic [PCW-1:0]               pidx_reg;
    logic [1:0]                   axis_reg;
    logic [1:0]                   chunk_reg;
    logic                         res_reach_reg;
    logic                         res_casc_reg;
    logic                         m_valid_reg;
    logic                         m_reach_reg;
    logic                         m_casc_reg;

    // Plane table.
    dir_t                         pl_n_reg   [MAX_PLANES][3];
    logic signed [OFFW-1:0]       pl_off_reg [MAX_PLANES];
    logic [MAX_PLANES-1:0]        pl_valid_reg;
    logic                         cascade_reg;

    // Reach table.
    logic signed [COORD_BITS-1:0] rc_x_reg [MAX_REACHES];
    logic signed [COORD_BITS-1:0] rc_y_reg [MAX_REACHES];
    logic signed [COORD_BITS-1:0] rc_z_reg [MAX_REACHES];
    logic [RAD_W-1:0]             rc_r_reg [MAX_REACHES];
    dir_t                         rc_f_reg [MAX_REACHES][3];
    logic [MAX_REACHES-1:0]       rc_valid_reg;

    logic [RIW-1:0]               ri;
    logic [PIW-1:0]               pi;
    logic signed [AW-1:0]         d_x, d_y, d_z, far_v, sel_v, shv, c_sel;
    dir_t                         chunk_b;
    logic signed [AW-1:0]         op_a;
    dir_t                         op_b;
    logic signed [ACCW-1:0]       acc_init, acc, lim_w;
    logic                         acc_pos, acc_neg;
    mac_ctl_t                     ctl;

    assign ri = ridx_reg[RIW-1:0];
    assign pi = pidx_reg[PIW-1:0];

    // Differences to the current reach and the summed radii.
    assign d_x   = AW'(cx_reg) - AW'(rc_x_reg[ri]);
    assign d_y   = AW'(cy_reg) - AW'(rc_y_reg[ri]);
    assign d_z   = AW'(cz_reg) - AW'(rc_z_reg[ri]);
    assign far_v = AW'({1'b0, r_reg} + {1'b0, rc_r_reg[ri]});

    always_comb begin
        case (axis_reg)
            2'd0:    sel_v = d_x;
            2'd1:    sel_v = d_y;
            2'd2:    sel_v = d_z;
            default: sel_v = far_v;
        endcase
        case (axis_reg)
            2'd0:    c_sel = AW'(cx_reg);
            2'd1:    c_sel = AW'(cy_reg);
            default: c_sel = AW'(cz_reg);
        endcase
    end

    // Chunk of the squared value: low chunks unsigned, the top one signed.
    assign shv     = sel_v >>> (CHUNK_W * int'(chunk_reg));
    assign chunk_b = (chunk_reg == CH_LAST) ? DIR_W'(shv) : {1'b0, shv[CHUNK_W-1:0]};

    assign lim_w = ACCW'($signed({1'b0, r_reg, {LIM_SHIFT{1'b0}}}));

    // Operand selection for the shared unit.
    always_comb begin
        op_a     = c_sel;
        op_b     = pl_n_reg[wslot_reg][axis_reg];
        acc_init = '0;
        case (state_reg)
            S_SQ: begin
                op_a = sel_v;
                op_b = chunk_b;
            end
            S_DOT: begin
                op_a     = sel_v;
                op_b     = rc_f_reg[ri][axis_reg];
                acc_init = lim_w;
            end
            S_PL: begin
                op_b     = pl_n_reg[pi][axis_reg];
                acc_init = -lim_w - ACCW'(pl_off_reg[pi]);
            end
            default: begin
                op_a = c_sel;
            end
        endcase
    end

    always_comb begin
        ctl.issue = (state_reg == S_WOFF) || (state_reg == S_SQ) ||
                    (state_reg == S_DOT) || (state_reg == S_PL);
        ctl.load  = ctl.issue && (axis_reg == 2'd0) && (chunk_reg == 2'd0);
        ctl.sub   = (state_reg == S_SQ) && (axis_reg == AX_FAR);
        ctl.chunk = (state_reg == S_SQ) ? chunk_reg : 2'd0;
    end

    ssc_mac #(
        .AW   (AW),
        .ACCW (ACCW)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .op_a     (op_a),
        .op_b     (op_b),
        .acc_init (acc_init),
        .acc      (acc)
    );

    assign acc_neg = acc[ACCW-1];
    assign acc_pos = !acc[ACCW-1] && (|acc);

    // Table storage, written only from the sequencer.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            if (s_opcode == OP_WPLANE && int'(s_slot) < MAX_PLANES && s_enable) begin
                pl_n_reg[PIW'(s_slot)][0] <= s_dir_x;
                pl_n_reg[PIW'(s_slot)][1] <= s_dir_y;
                pl_n_reg[PIW'(s_slot)][2] <= s_dir_z;
            end
            if (s_opcode == OP_WREACH && int'(s_slot) < MAX_REACHES && s_enable) begin
                rc_x_reg[RIW'(s_slot)]    <= s_pos_x;
                rc_y_reg[RIW'(s_slot)]    <= s_pos_y;
                rc_z_reg[RIW'(s_slot)]    <= s_pos_z;
                rc_r_reg[RIW'(s_slot)]    <= s_radius;
                rc_f_reg[RIW'(s_slot)][0] <= s_dir_x;
                rc_f_reg[RIW'(s_slot)][1] <= s_dir_y;
                rc_f_reg[RIW'(s_slot)][2] <= s_dir_z;
            end
        end
        if (state_reg == S_WST) begin
            pl_off_reg[wslot_reg] <= OFFW'(acc);
        end
    end

    // Item registers.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            cx_reg    <= s_pos_x;
            cy_reg    <= s_pos_y;
            cz_reg    <= s_pos_z;
            r_reg     <= s_radius;
            wslot_reg <= PIW'(s_slot);
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pl_valid_reg  <= '0;
            rc_valid_reg  <= '0;
            cascade_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            ridx_reg      <= '0;
            pidx_reg      <= '0;
            axis_reg      <= '0;
            chunk_reg     <= '0;
            res_reach_reg <= 1'b0;
            res_casc_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        res_reach_reg <= 1'b0;
                        res_casc_reg  <= 1'b0;
                        axis_reg      <= '0;
                        chunk_reg     <= '0;
                        ridx_reg      <= '0;
                        pidx_reg      <= '0;
                        case (s_opcode)
                            OP_WPLANE: begin
                                if (int'(s_slot) < MAX_PLANES) begin
                                    cascade_reg <= 1'b1;
                                    if (s_enable) begin
                                        state_reg <= S_WOFF;
                                    end else begin
                                        pl_valid_reg[PIW'(s_slot)] <= 1'b0;
                                        state_reg                  <= S_DONE;
                                    end
                                end else begin
                                    state_reg <= S_DONE;
                                end
                            end
                            OP_WREACH: begin
                                if (int'(s_slot) < MAX_REACHES) begin
                                    rc_valid_reg[RIW'(s_slot)] <= s_enable;
                                end
                                state_reg <= S_DONE;
                            end
                            OP_TEST: begin
                                state_reg <= S_RSCAN;
                            end
                            default: begin
                                pl_valid_reg <= '0;
                                rc_valid_reg <= '0;
                                cascade_reg  <= 1'b0;
                                state_reg    <= S_DONE;
                            end
                        endcase
                    end
                end
                // Plane offset: dot of point and normal.
                S_WOFF: begin
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == AX_LAST) begin
                        state_reg <= S_WFL;
                    end
                end
                S_WFL: begin
                    state_reg <= S_WST;
                end
                S_WST: begin
                    pl_valid_reg[wslot_reg] <= 1'b1;
                    state_reg               <= S_DONE;
                end
                // Walk the reach table.
                S_RSCAN: begin
                    axis_reg  <= '0;
                    chunk_reg <= '0;
                    if (ridx_reg == RCW'(MAX_REACHES)) begin
                        pidx_reg <= '0;
                        if (cascade_reg) begin
                            res_casc_reg <= 1'b1;
                            state_reg    <= S_PSCAN;
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end else if (rc_valid_reg[ri]) begin
                        state_reg <= S_SQ;
                    end else begin
                        ridx_reg <= ridx_reg + 1'b1;
                    end
                end
                // Squared distance minus squared summed radii.
                S_SQ: begin
                    if (chunk_reg == CH_LAST) begin
                        chunk_reg <= '0;
                        axis_reg  <= axis_reg + 2'd1;
                        if (axis_reg == AX_FAR) begin
                            state_reg <= S_SQFL;
                        end
                    end else begin
                        chunk_reg <= chunk_reg + 2'd1;
                    end
                end
                S_SQFL: begin
                    state_reg <= S_SQCHK;
                end
                S_SQCHK: begin
                    axis_reg  <= '0;
                    chunk_reg <= '0;
                    if (acc_pos) begin
                        ridx_reg  <= ridx_reg + 1'b1;
                        state_reg <= S_RSCAN;
                    end else begin
                        state_reg <= S_DOT;
                    end
                end
                // Distance along the facing plus the tested radius.
                S_DOT: begin
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == AX_LAST) begin
                        state_reg <= S_DOTFL;
                    end
                end
                S_DOTFL: begin
                    state_reg <= S_DOTCHK;
                end
                S_DOTCHK: begin
                    state_reg <= S_RSCAN;
                    if (acc_neg) begin
                        ridx_reg <= ridx_reg + 1'b1;
                    end else begin
                        res_reach_reg <= 1'b1;
                        ridx_reg      <= RCW'(MAX_REACHES);
                    end
                end
                // Walk the plane table.
                S_PSCAN: begin
                    axis_reg  <= '0;
                    chunk_reg <= '0;
                    if (pidx_reg == PCW'(MAX_PLANES)) begin
                        state_reg <= S_DONE;
                    end else if (pl_valid_reg[pi]) begin
                        state_reg <= S_PL;
                    end else begin
                        pidx_reg <= pidx_reg + 1'b1;
                    end
                end
                S_PL: begin
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == AX_LAST) begin
                        state_reg <= S_PLFL;
                    end
                end
                S_PLFL: begin
                    state_reg <= S_PLCHK;
                end
                S_PLCHK: begin
                    if (acc_pos) begin
                        res_casc_reg <= 1'b0;
                        state_reg    <= S_DONE;
                    end else begin
                        pidx_reg  <= pidx_reg + 1'b1;
                        state_reg <= S_PSCAN;
                    end
                end
                // Hand the result word to the output register.
                default: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Output word payload.
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            m_reach_reg <= res_reach_reg;
            m_casc_reg  <= res_casc_reg;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_by_reach   = m_reach_reg;
    assign m_by_cascade = m_casc_reg;
    assign m_visible    = m_reach_reg | m_casc_reg;

endmodule

>>> dv/tb_shadow_sphere_cull.sv
// ----------------------------------------------------------------------------
// tb_shadow_sphere_cull: self-checking bench for the shadow sphere cull block
// Loads plane and reach tables, tests spheres against them and compares each
// result word with an in-bench prediction, under random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_shadow_sphere_cull;
    import ssc_pkg::*;

    localparam int NPL = 8;
    localparam int NRC = 16;

    typedef struct {
        logic [1:0]         opcode;
        logic [3:0]         slot;
        logic signed [31:0] px, py, pz;
        dir_t               dx, dy, dz;
        logic [30:0]        radius;
        logic               enable;
    } cmd_t;

    typedef struct {
        logic visible;
        logic by_reach;
        logic by_cascade;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_opcode = '0;
    logic [3:0] s_slot = '0;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    dir_t s_dir_x = '0, s_dir_y = '0, s_dir_z = '0;
    logic [30:0] s_radius = '0;
    logic s_enable = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_visible, m_by_reach, m_by_cascade;

    shadow_sphere_cull uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_slot(s_slot),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .s_radius(s_radius), .s_enable(s_enable),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_visible(m_visible), .m_by_reach(m_by_reach), .m_by_cascade(m_by_cascade)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the block's tables.
    dir_t               pl_n[NPL][3];
    logic signed [51:0] pl_off[NPL];
    logic [NPL-1:0]     pl_on;
    logic               region_on;
    logic signed [31:0] rc_c[NRC][3];
    logic [30:0]        rc_r[NRC];
    dir_t               rc_f[NRC][3];
    logic [NRC-1:0]     rc_on;

    cmd_t     pending_cmds[$];
    verdict_t expected_verdicts[$];

    int send_idle = 25;
    int recv_idle = 59;
    bit hold_sink = 0;
    int n_sent = 0, n_words = 0, n_tests = 0, n_reach_hits = 0, n_casc_hits = 0;
    int n_bad = 0;

    // Work out the result word of one command and update the tables.
    function automatic verdict_t cull_step(cmd_t c);
        verdict_t v;
        logic signed [33:0]  d[3];
        logic [69:0]         dist2, far2;
        logic [31:0]         far;
        logic signed [55:0]  along, h;
        logic signed [55:0]  lim;
        logic                hit, held;
        v = '{1'b0, 1'b0, 1'b0};
        case (c.opcode)
            OP_WPLANE: if (c.slot < NPL) begin
                region_on = 1'b1;
                if (c.enable) begin
                    pl_n[c.slot][0] = c.dx;
                    pl_n[c.slot][1] = c.dy;
                    pl_n[c.slot][2] = c.dz;
                    pl_off[c.slot] = 52'(56'(c.px) * c.dx + 56'(c.py) * c.dy
                                       + 56'(c.pz) * c.dz);
                    pl_on[c.slot] = 1'b1;
                end else begin
                    pl_on[c.slot] = 1'b0;
                end
            end
            OP_WREACH: if (c.slot < NRC) begin
                if (c.enable) begin
                    rc_c[c.slot][0] = c.px;
                    rc_c[c.slot][1] = c.py;
                    rc_c[c.slot][2] = c.pz;
                    rc_r[c.slot] = c.radius;
                    rc_f[c.slot][0] = c.dx;
                    rc_f[c.slot][1] = c.dy;
                    rc_f[c.slot][2] = c.dz;
                    rc_on[c.slot] = 1'b1;
                end else begin
                    rc_on[c.slot] = 1'b0;
                end
            end
            OP_TEST: begin
                lim = {25'd0, c.radius} <<< 16;
                hit = 1'b0;
                for (int k = 0; k < NRC; k++) begin
                    if (rc_on[k] && !hit) begin
                        d[0] = 34'(c.px) - 34'(rc_c[k][0]);
                        d[1] = 34'(c.py) - 34'(rc_c[k][1]);
                        d[2] = 34'(c.pz) - 34'(rc_c[k][2]);
                        dist2 = 70'(d[0] * d[0]) + 70'(d[1] * d[1]) + 70'(d[2] * d[2]);
                        far = 32'(rc_r[k]) + 32'(c.radius);
                        far2 = 70'(far) * 70'(far);
                        along = 56'(d[0]) * rc_f[k][0] + 56'(d[1]) * rc_f[k][1]
                              + 56'(d[2]) * rc_f[k][2];
                        hit = (dist2 <= far2) && !(along < -lim);
                    end
                end
                held = region_on;
                for (int p = 0; p < NPL; p++) begin
                    if (pl_on[p]) begin
                        h = 56'(c.px) * pl_n[p][0] + 56'(c.py) * pl_n[p][1]
                          + 56'(c.pz) * pl_n[p][2] - 56'(pl_off[p]);
                        if (h > 0 && h > lim) held = 1'b0;
                    end
                end
                v.by_reach = hit;
                v.by_cascade = held;
                v.visible = hit | held;
            end
            default: begin
                pl_on = '0;
                rc_on = '0;
                region_on = 1'b0;
            end
        endcase
        return v;
    endfunction

    function automatic dir_t rand_dir();
        case ($urandom_range(0, 5))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'($urandom);
            default: return dir_t'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'($urandom);
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic cmd_t make_cmd(logic [1:0] op, logic [3:0] sl,
                                      logic signed [31:0] x, y, z,
                                      dir_t a, b, e, logic [30:0] r, logic en);
        cmd_t c;
        c.opcode = op; c.slot = sl; c.px = x; c.py = y; c.pz = z;
        c.dx = a; c.dy = b; c.dz = e; c.radius = r; c.enable = en;
        return c;
    endfunction

    // A mostly well-formed random command against small scene coordinates.
    function automatic cmd_t rand_cmd();
        cmd_t c;
        int sel;
        sel = $urandom_range(0, 99);
        c = make_cmd(OP_TEST, 4'($urandom), rand_coord(), rand_coord(), rand_coord(),
                     rand_dir(), rand_dir(), rand_dir(),
                     ($urandom_range(0, 9) == 0) ? 31'($urandom)
                                                : 31'($urandom_range(0, 32'h0010_0000)),
                     $urandom_range(0, 5) != 0);
        if (sel < 15) begin
            c.opcode = OP_WPLANE;
            if ($urandom_range(0, 3) != 0) c.slot = 4'($urandom_range(0, NPL - 1));
        end else if (sel < 35) begin
            c.opcode = OP_WREACH;
        end else if (sel < 37) begin
            c.opcode = OP_CLEAR;
        end
        return c;
    endfunction

    // Append one command to the tail of the pending queue.
    task automatic queue_cmd(cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Driver: present queued words, holding each until it is taken.
    always @(posedge aclk) begin
        if (aresetn && (!s_valid || s_ready)) begin
            if (s_valid) n_sent <= n_sent + 1;
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                cmd_t c;
                c = pending_cmds.pop_front();
                expected_verdicts.insert(expected_verdicts.size(), cull_step(c));
                s_valid <= 1'b1;
                s_opcode <= c.opcode; s_slot <= c.slot;
                s_pos_x <= c.px; s_pos_y <= c.py; s_pos_z <= c.pz;
                s_dir_x <= c.dx; s_dir_y <= c.dy; s_dir_z <= c.dz;
                s_radius <= c.radius; s_enable <= c.enable;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    n_bad = n_bad + 1;
                    if (n_bad <= 10) $display("ERROR: result word with none expected");
                end else begin
                    verdict_t v;
                    v = expected_verdicts.pop_front();
                    n_words = n_words + 1;
                    if (v.by_reach) n_reach_hits = n_reach_hits + 1;
                    if (v.by_cascade) n_casc_hits = n_casc_hits + 1;
                    if (m_visible !== v.visible || m_by_reach !== v.by_reach
                        || m_by_cascade !== v.by_cascade) begin
                        n_bad = n_bad + 1;
                        if (n_bad <= 10)
                            $display("ERROR: word %0d exp vis/reach/casc %b%b%b got %b%b%b",
                                     n_words, v.visible, v.by_reach, v.by_cascade,
                                     m_visible, m_by_reach, m_by_cascade);
                    end
                end
            end
            m_ready <= !hold_sink && ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_valid || expected_verdicts.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty scene, region with no planes, extremes, removals.
        queue_cmd(make_cmd(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_WPLANE, 9, 0, 0, 0, 0, 0, 0, 0, 1));
        queue_cmd(make_cmd(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_WPLANE, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_TEST, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                           0, 0, 0, 31'h7FFF_FFFF, 1));
        queue_cmd(make_cmd(OP_WPLANE, 7, 32'sh0001_0000, 0, 0,
                           18'sd65536, 0, 0, 0, 1));
        queue_cmd(make_cmd(OP_WPLANE, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                           32'sh8000_0000, -18'sd65536, 18'sh1FFFF,
                           18'sh20000, 0, 1));
        queue_cmd(make_cmd(OP_TEST, 5, 32'sh0003_0000, 0, 0, 0, 0, 0,
                           31'h0001_0000, 0));
        queue_cmd(make_cmd(OP_TEST, 5, 32'sh0003_0000, 0, 0, 0, 0, 0,
                           31'h0003_0000, 0));
        queue_cmd(make_cmd(OP_WREACH, 15, 0, 0, 0, 0, 0, 18'sd65536,
                           31'h0002_0000, 1));
        queue_cmd(make_cmd(OP_WREACH, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           32'sh7FFF_FFFF, 18'sh20000, 18'sh20000,
                           18'sh20000, 31'h7FFF_FFFF, 1));
        queue_cmd(make_cmd(OP_TEST, 0, 0, 0, 32'sh0001_0000, 0, 0, 0,
                           31'h0001_0000, 0));
        queue_cmd(make_cmd(OP_TEST, 0, 0, 0, -32'sh0002_8000, 0, 0, 0,
                           31'h0000_8000, 0));
        queue_cmd(make_cmd(OP_TEST, 0, 32'sh8000_0000, 32'sh8000_0000,
                           32'sh8000_0000, 0, 0, 0, 31'h7FFF_FFFF, 0));
        queue_cmd(make_cmd(OP_WREACH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_WPLANE, 7, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_TEST, 1, 32'sh0010_0000, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_TEST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // Random phases with each idling profile.
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle = 59; recv_idle = 25; end
            if (ph == 2) begin send_idle = 0; recv_idle = 0; end
            for (int i = 0; i < 580; i++) queue_cmd(rand_cmd());
            if (ph == 2) begin
                // Hold the sink off long enough for the input side to stall.
                repeat (20) @(posedge aclk);
                hold_sink = 1;
                repeat (400) @(posedge aclk);
                hold_sink = 0;
            end
            wait_drained();
        end
        repeat (600) @(posedge aclk);

        $display("Covered %0d words sent, %0d results, %0d reach hits, %0d region hits.",
                 n_sent, n_words, n_reach_hits, n_casc_hits);
        if (n_bad == 0 && expected_verdicts.size() == 0)
            $display("shadow_sphere_cull test passed");
        else
            $display("shadow_sphere_cull test failed");
        $finish;
    end

    initial begin
        pl_on = '0;
        rc_on = '0;
        region_on = 1'b0;
    end

    initial begin
        #100ms;
        $display("shadow_sphere_cull test failed");
        $finish;
    end

endmodule
